[rtl/alpha_mask_shape_rasterizer_macros.svh]
// Assertion macros shared by the alpha mask rasterizer checkers.
`ifndef ALPHA_MASK_SHAPE_RASTERIZER_MACROS_SVH
`define ALPHA_MASK_SHAPE_RASTERIZER_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define AMSR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define AMSR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/amsr_pkg.sv]
// Shared constants, types and helpers of the alpha mask shape rasterizer.
`default_nettype none

package amsr_pkg;

	// Mask geometry.
	localparam int MASK_SIDE  = 32;
	localparam int COORD_W    = $clog2(MASK_SIDE);
	localparam int MASK_DEPTH = MASK_SIDE * MASK_SIDE;
	localparam int ADDR_W     = $clog2(MASK_DEPTH);

	// Field widths.
	localparam int KIND_W    = 3;
	localparam int POS_W     = 7;
	localparam int ALPHA_W   = 8;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	// Distance arithmetic: signed differences, magnitudes, squares and their sum.
	localparam int DIFF_W = 8;
	localparam int MAG_W  = 7;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int D2_W   = SQ_W + 1;

	// Command kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 3'd0,
		KIND_RECT   = 3'd1,
		KIND_CIRCLE = 3'd2,
		KIND_RING   = 3'd3,
		KIND_READ   = 3'd4
	} kind_t;

	// Magnitude of a signed difference.
	function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
		logic signed [DIFF_W-1:0] n;
		n = -v;
		return v[DIFF_W-1] ? MAG_W'(n) : MAG_W'(v);
	endfunction

endpackage

`default_nettype wire

[rtl/amsr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module amsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[rtl/alpha_mask_shape_rasterizer.sv]
// Alpha mask shape rasterizer: 32 by 32 alpha mask with max-blended shape drawing.
//
// Commands enter on the s_ channel (s_tuser carries the kind, s_tdata the operands) and
// every command gives exactly one item on the m_ channel: the pixel alpha for a read,
// zero for everything else. The block works on one command at a time; s_tready is high
// only while it is idle, and it may take a new command while the previous result waits.
// Steps from acceptance to result valid:
//   clear and unused kinds: straight to the finish state
//   read pixel: one registered mask read
//   rectangle, circle, ring: radius squaring, then every row of MASK_SIDE pixels
// A shape walks every pixel once through one squaring unit, which also squares the radii
// and, in a row state ahead of each row, the row distance; each pixel is a read-modify-write of
// the mask memory. Reset is immediate: per-row valid bits make unwritten rows read as
// zero, and a clear command drops them all at once. When the receiver stalls, the
// result stays in the output register and the next command finishes only once it is taken.
`default_nettype none

module alpha_mask_shape_rasterizer
	import amsr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // x_a[6:0] y_a[13:7] x_b[20:14] y_b[27:21] alpha[35:28]
	input  wire logic [KIND_W-1:0]    s_tuser,  // kind[2:0]
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata   // read_value[7:0]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_OUTER,
		ST_SQ_INNER,
		ST_ROW,
		ST_PIX,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_FINISH
	} state_t;

	localparam logic [COORD_W-1:0]       LAST_C = COORD_W'(MASK_SIDE - 1);
	localparam logic signed [DIFF_W-1:0] SIDE_S = DIFF_W'(MASK_SIDE);

	state_t                     state_q;
	kind_t                      kind_q;
	logic signed [POS_W-1:0]    xa_q, ya_q, xb_q, yb_q;
	logic [ALPHA_W-1:0]         alpha_q;
	logic [COORD_W-1:0]         x_q, y_q;
	logic [SQ_W-1:0]            ro2_q, ri2_q, dy2_q;
	logic [ALPHA_W-1:0]         res_q;
	logic                       rd_vld_q;
	logic                       m_tvalid_q;
	logic [M_TDATA_W-1:0]       m_tdata_q;
	logic [MASK_SIDE-1:0]       row_vld_q;

	// Read-modify-write stage.
	logic                       act_s1;
	logic                       vld_s1;
	logic [COORD_W-1:0]         x_s1, y_s1;
	logic [SQ_W-1:0]            sq_s1;

	logic signed [DIFF_W-1:0]   xa_e, ya_e, xb_e, yb_e;
	logic signed [DIFF_W-1:0]   dx, dy, x1, y1;
	logic [MAG_W-1:0]           sq_in;
	logic [SQ_W-1:0]            sq;
	logic [D2_W-1:0]            d2;
	logic                       in_rect, in_disc, hit;
	logic                       rd_inside;
	logic                       clear_go;
	logic [ALPHA_W-1:0]         old_a, wr_a;
	logic [ADDR_W-1:0]          raddr, waddr;
	logic [ALPHA_W-1:0]         rdata;

	function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] row,
		input logic [COORD_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(MASK_SIDE) + ADDR_W'(col));
	endfunction

	// Operands extended to the difference width.
	assign xa_e = DIFF_W'(xa_q);
	assign ya_e = DIFF_W'(ya_q);
	assign xb_e = DIFF_W'(xb_q);
	assign yb_e = DIFF_W'(yb_q);
	assign dx   = signed'(DIFF_W'(x_q)) - xa_e;
	assign dy   = signed'(DIFF_W'(y_q)) - ya_e;

	// Shared squaring unit: radii during setup, row distance per row, column distance per pixel.
	always_comb begin
		case (state_q)
			ST_SQ_OUTER: sq_in = mag(xb_e);
			ST_SQ_INNER: sq_in = mag(yb_e);
			ST_ROW:      sq_in = mag(dy);
			default:     sq_in = mag(dx);
		endcase
	end
	assign sq = SQ_W'(sq_in) * SQ_W'(sq_in);

	// Pixel test on the registered stage.
	assign x1      = signed'(DIFF_W'(x_s1));
	assign y1      = signed'(DIFF_W'(y_s1));
	assign d2      = D2_W'(sq_s1) + D2_W'(dy2_q);
	assign in_rect = (x1 >= xa_e) && (x1 <= xb_e) && (y1 >= ya_e) && (y1 <= yb_e);
	assign in_disc = !xb_q[POS_W-1] && (d2 <= D2_W'(ro2_q));

	always_comb begin
		case (kind_q)
			KIND_RECT:   hit = in_rect;
			KIND_CIRCLE: hit = in_disc;
			KIND_RING:   hit = in_disc && (d2 >= D2_W'(ri2_q));
			default:     hit = 1'b0;
		endcase
	end

	// Max blend; a row never written since the last clear reads as zero.
	assign old_a = vld_s1 ? rdata : '0;
	assign wr_a  = (hit && (alpha_q > old_a)) ? alpha_q : old_a;
	assign waddr = pix_addr(y_s1, x_s1);
	assign raddr = (state_q == ST_PIX) ? pix_addr(y_q, x_q)
		: pix_addr(ya_q[COORD_W-1:0], xa_q[COORD_W-1:0]);

	assign rd_inside = (xa_e >= 0) && (xa_e < SIDE_S) && (ya_e >= 0) && (ya_e < SIDE_S);
	assign clear_go  = (state_q == ST_IDLE) && s_tvalid && (kind_t'(s_tuser) == KIND_CLEAR);

	amsr_ram #(
		.WIDTH(ALPHA_W),
		.DEPTH(MASK_DEPTH)
	) u_mask (
		.clk  (clk),
		.we   (act_s1),
		.waddr(waddr),
		.wdata(wr_a),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Read-modify-write stage and per-row valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1    <= 1'b0;
			vld_s1    <= 1'b0;
			x_s1      <= '0;
			y_s1      <= '0;
			sq_s1     <= '0;
			row_vld_q <= '0;
		end else begin
			act_s1 <= (state_q == ST_PIX);
			vld_s1 <= row_vld_q[y_q];
			x_s1   <= x_q;
			y_s1   <= y_q;
			sq_s1  <= sq;
			if (clear_go) begin
				row_vld_q <= '0;
			end else if (act_s1 && (x_s1 == LAST_C)) begin
				row_vld_q[y_s1] <= 1'b1;
			end
		end
	end

	// Command sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			kind_q     <= KIND_CLEAR;
			xa_q       <= '0;
			ya_q       <= '0;
			xb_q       <= '0;
			yb_q       <= '0;
			alpha_q    <= '0;
			x_q        <= '0;
			y_q        <= '0;
			ro2_q      <= '0;
			ri2_q      <= '0;
			dy2_q      <= '0;
			res_q      <= '0;
			rd_vld_q   <= 1'b0;
			m_tdata_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// The finish state reloads the output register itself.
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= kind_t'(s_tuser);
						xa_q    <= s_tdata[6:0];
						ya_q    <= s_tdata[13:7];
						xb_q    <= s_tdata[20:14];
						yb_q    <= s_tdata[27:21];
						alpha_q <= s_tdata[35:28];
						x_q     <= '0;
						y_q     <= '0;
						case (kind_t'(s_tuser))
							KIND_RECT, KIND_CIRCLE, KIND_RING: state_q <= ST_SQ_OUTER;
							KIND_READ: state_q <= ST_RD_ADDR;
							default: begin
								res_q   <= '0;
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_SQ_OUTER: begin
					ro2_q   <= sq;
					state_q <= ST_SQ_INNER;
				end
				ST_SQ_INNER: begin
					ri2_q   <= sq;
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					dy2_q   <= sq;
					state_q <= ST_PIX;
				end
				ST_PIX: begin
					if (x_q == LAST_C) begin
						x_q <= '0;
						if (y_q == LAST_C) begin
							res_q   <= '0;
							state_q <= ST_FINISH;
						end else begin
							y_q     <= y_q + COORD_W'(1);
							state_q <= ST_ROW;
						end
					end else begin
						x_q <= x_q + COORD_W'(1);
					end
				end
				ST_RD_ADDR: begin
					rd_vld_q <= rd_inside && row_vld_q[ya_q[COORD_W-1:0]];
					state_q  <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					res_q   <= rd_vld_q ? rdata : '0;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= res_q;
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

[rtl/amsr_checker.sv]
// Port-level checker for the alpha mask shape rasterizer, bound to the top level.
`default_nettype none
`include "alpha_mask_shape_rasterizer_macros.svh"

module amsr_checker
	import amsr_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);

	// A stalled result item stays offered and unchanged.
	`AMSR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")
	`AMSR_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result item changed while stalled")

	// One command at a time: busy right after an item is taken.
	`AMSR_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after accepting an item")

	// A result never appears in the cycle after acceptance, and only out of a busy cycle.
	`AMSR_ASSERT_NXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid), "result too early")
	`AMSR_ASSERT_IMP(a_result_from_busy, $rose(m_tvalid), !$past(s_tready), "result while idle")

endmodule

bind alpha_mask_shape_rasterizer amsr_checker u_amsr_checker (.*);

`default_nettype wire
